>>> hw/rtl/assert_macros.svh
// Assertion macros used by the decoder RTL.
// No dependencies; the including module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CHD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define CHD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/chd_pkg.sv
// Package for the canonical Huffman decoder: payload structs, table entry type, codes.
// No dependencies.
`default_nettype none
package chd_pkg;

  localparam int NumSymbolsDef       = 256;
  localparam int MaxCodeBitsDef      = 32;
  localparam int MaxLengthClassesDef = 32;
  localparam int FlushBits           = 32;

  localparam logic [1:0] FUNC_CLASS  = 2'd0;
  localparam logic [1:0] FUNC_SYMBOL = 2'd1;
  localparam logic [1:0] FUNC_DATA   = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  entry_index;
    logic [5:0]  class_length;
    logic [31:0] class_first_code;
    logic [7:0]  class_rank;
    logic [7:0]  symbol_value;
    logic [31:0] data_word;
    logic        last_word;
    logic [5:0]  last_word_bits;
  } in_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic [5:0] code_length;
    logic       last_of_run;
    logic       end_of_message;
    logic       overrun;
  } out_t;

  typedef struct packed {
    logic [5:0]  length;
    logic [31:0] first_code;
    logic [7:0]  rank;
  } class_entry_t;

endpackage
`default_nettype wire

>>> hw/rtl/canonical_huffman_decoder.sv
// Canonical Huffman decoder: one shared compare/subtract/shift unit under a small sequencer.
// Load items are written from idle; a data word is accepted, then checked, then each symbol
// takes a class scan (probe and compare per class stepped past), a fetch and a lookup, plus output stalls.
// One item at a time; in_ready is high only while the sequencer is idle.
// Synchronous active-low reset clears window, bit count, num_lengths (to 1) and control.
// Tables have no reset; depends on chd_pkg, chd_tables and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module canonical_huffman_decoder #(
  parameter int NUM_SYMBOLS        = chd_pkg::NumSymbolsDef,
  parameter int MAX_CODE_BITS      = chd_pkg::MaxCodeBitsDef,
  parameter int MAX_LENGTH_CLASSES = chd_pkg::MaxLengthClassesDef
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  chd_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output chd_pkg::out_t       out_data,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [2:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import chd_pkg::*;

  localparam int ClsAw = (MAX_LENGTH_CLASSES > 1) ? $clog2(MAX_LENGTH_CLASSES) : 1;
  localparam int SymAw = $clog2(NUM_SYMBOLS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_PROBE, ST_COMPARE, ST_FETCH, ST_LOOKUP
  } state_t;

  state_t       state_r, state_nxt;
  logic [63:0]  window_r, window_nxt;
  logic [6:0]   held_r, held_nxt;
  logic         last_r, last_nxt;
  logic [ClsAw-1:0] d_r, d_nxt;
  logic [5:0]   len_r, len_nxt;
  logic         idx_ok_r, idx_ok_nxt;
  out_t         out_r, out_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [5:0]   num_lengths_r, num_lengths_nxt;

  // table ports
  logic             cls_we, sym_we;
  logic [ClsAw-1:0] cls_raddr;
  class_entry_t     cls_rdata, cls_wdata;
  logic [SymAw-1:0] sym_raddr;
  logic [7:0]       sym_rdata;

  chd_tables #(
    .NUM_SYMBOLS       (NUM_SYMBOLS),
    .MAX_LENGTH_CLASSES(MAX_LENGTH_CLASSES)
  ) u_tables (
    .clk      (clk),
    .cls_we   (cls_we),
    .cls_waddr(in_data.entry_index[ClsAw-1:0]),
    .cls_wdata(cls_wdata),
    .cls_raddr(cls_raddr),
    .cls_rdata(cls_rdata),
    .sym_we   (sym_we),
    .sym_waddr(in_data.entry_index[SymAw-1:0]),
    .sym_wdata(in_data.symbol_value),
    .sym_raddr(sym_raddr),
    .sym_rdata(sym_rdata)
  );

  assign cls_wdata = '{length: in_data.class_length, first_code: in_data.class_first_code,
                       rank: in_data.class_rank};

  // APB side: one register, byte lanes ignored, address bit 2 selects beyond the list
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {26'd0, num_lengths_r};

  // Effective class count: zero acts as one, clamp to table depth
  logic [5:0] cnt;
  always_comb begin
    if (num_lengths_r == 6'd0) begin
      cnt = 6'd1;
    end else if (num_lengths_r > 6'(MAX_LENGTH_CLASSES)) begin
      cnt = 6'(MAX_LENGTH_CLASSES);
    end else begin
      cnt = num_lengths_r;
    end
  end

  logic [31:0] top;
  logic [5:0]  d_ext, d_plus;
  assign top    = window_r[63:32];
  assign d_ext  = 6'(d_r);
  assign d_plus = d_ext + 6'd1;

  // Append path for a data word
  logic [5:0]  add6;
  logic [31:0] word_m;
  logic [5:0]  app_sh;
  always_comb begin
    add6   = 6'd32;
    word_m = in_data.data_word;
    if (in_data.last_word) begin
      add6 = (in_data.last_word_bits > 6'd32) ? 6'd32 : in_data.last_word_bits;
      if (add6 == 6'd0) begin
        word_m = 32'd0;
      end else if (add6 < 6'd32) begin
        word_m = in_data.data_word & ~(32'hFFFF_FFFF >> add6);
      end
    end
    app_sh = 6'd32 - {1'b0, held_r[4:0]};
  end

  // Shared decode unit: clamp length, offset within the class, rank plus offset
  logic [5:0]  cls_len;
  logic [31:0] diff, off;
  logic [7:0]  idx;
  always_comb begin
    cls_len = cls_rdata.length;
    if (cls_len == 6'd0) begin
      cls_len = 6'd1;
    end else if (cls_len > 6'(MAX_CODE_BITS)) begin
      cls_len = 6'(MAX_CODE_BITS);
    end
    diff = top - cls_rdata.first_code;
    off  = diff >> (6'(FlushBits) - cls_len);
    idx  = cls_rdata.rank + off[7:0];
  end

  // Emit side: bits left after this code, and whether the run ends here
  logic [6:0] len7, held_after;
  logic       ovr, run_done;
  always_comb begin
    len7       = 7'(len_r);
    ovr        = len7 > held_r;
    held_after = (len7 >= held_r) ? 7'd0 : held_r - len7;
    run_done   = last_r ? (held_after == 7'd0) : (held_after < 7'(MAX_CODE_BITS));
  end

  always_comb begin
    state_nxt       = state_r;
    window_nxt      = window_r;
    held_nxt        = held_r;
    last_nxt        = last_r;
    d_nxt           = d_r;
    len_nxt         = len_r;
    idx_ok_nxt      = idx_ok_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r & ~out_ready;
    num_lengths_nxt = num_lengths_r;
    cls_we          = 1'b0;
    sym_we          = 1'b0;
    cls_raddr       = d_r;
    sym_raddr       = idx[SymAw-1:0];

    if (psel && penable && pwrite && !paddr[2]) begin
      num_lengths_nxt = pwdata[5:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.func)
            FUNC_CLASS: begin
              cls_we = {1'b0, in_data.entry_index} < 9'(MAX_LENGTH_CLASSES);
            end
            FUNC_SYMBOL: begin
              sym_we = {1'b0, in_data.entry_index} < 9'(NUM_SYMBOLS);
            end
            FUNC_DATA: begin
              // append left-aligned below the held bits
              window_nxt = window_r | ({32'd0, word_m} << app_sh);
              held_nxt   = held_r + {1'b0, add6};
              last_nxt   = in_data.last_word;
              state_nxt  = ST_CHECK;
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (last_r ? (held_r == 7'd0) : (held_r < 7'(MAX_CODE_BITS))) begin
          if (last_r) begin
            window_nxt = '0;
            held_nxt   = '0;
          end
          state_nxt = ST_IDLE;
        end else begin
          d_nxt     = '0;
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        // read the next class if there is one, else the current class
        if (d_plus < cnt) begin
          cls_raddr = d_plus[ClsAw-1:0];
          state_nxt = ST_COMPARE;
        end else begin
          state_nxt = ST_FETCH;
        end
      end
      ST_COMPARE: begin
        if (top >= cls_rdata.first_code) begin
          d_nxt     = d_plus[ClsAw-1:0];
          state_nxt = ST_PROBE;
        end else begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        len_nxt    = cls_len;
        idx_ok_nxt = {1'b0, idx} < 9'(NUM_SYMBOLS);
        state_nxt  = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        // hold until the output register frees up
        if (!out_valid_r || out_ready) begin
          out_nxt.symbol         = idx_ok_r ? sym_rdata : 8'd0;
          out_nxt.code_length    = len_r;
          out_nxt.last_of_run    = run_done;
          out_nxt.end_of_message = run_done & last_r;
          out_nxt.overrun        = ovr;
          out_valid_nxt          = 1'b1;
          window_nxt             = window_r << len_r;
          held_nxt               = held_after;
          d_nxt                  = '0;
          if (run_done) begin
            if (last_r) begin
              window_nxt = '0;
              held_nxt   = '0;
            end
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_PROBE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      window_r      <= '0;
      held_r        <= '0;
      last_r        <= 1'b0;
      d_r           <= '0;
      out_valid_r   <= 1'b0;
      num_lengths_r <= 6'd1;
    end else begin
      state_r       <= state_nxt;
      window_r      <= window_nxt;
      held_r        <= held_nxt;
      last_r        <= last_nxt;
      d_r           <= d_nxt;
      out_valid_r   <= out_valid_nxt;
      num_lengths_r <= num_lengths_nxt;
    end
    len_r    <= len_nxt;
    idx_ok_r <= idx_ok_nxt;
    out_r    <= out_nxt;
  end

  // Idle always leaves less than a full code in the window
  `CHD_ASSERT_IMPL(a_idle_held, state_r == ST_IDLE, held_r < 7'(MAX_CODE_BITS))
  // Class scan never walks past the loaded classes
  `CHD_ASSERT_IMPL(a_scan_bound, state_r == ST_PROBE || state_r == ST_COMPARE, d_ext < cnt)
  // A pending result is not overwritten while stalled
  `CHD_ASSERT_NEXT(a_out_hold, out_valid_r && !out_ready, out_valid_r && $stable(out_r))

endmodule
`default_nettype wire

>>> hw/rtl/chd_tables.sv
// Class table and rank-to-symbol table, each one write port and one registered read.
// Depends on chd_pkg.
`default_nettype none
module chd_tables #(
  parameter int NUM_SYMBOLS        = chd_pkg::NumSymbolsDef,
  parameter int MAX_LENGTH_CLASSES = chd_pkg::MaxLengthClassesDef,
  localparam int ClsAw = (MAX_LENGTH_CLASSES > 1) ? $clog2(MAX_LENGTH_CLASSES) : 1,
  localparam int SymAw = $clog2(NUM_SYMBOLS)
) (
  input  wire                        clk,
  input  wire                        cls_we,
  input  wire  [ClsAw-1:0]           cls_waddr,
  input  wire  chd_pkg::class_entry_t cls_wdata,
  input  wire  [ClsAw-1:0]           cls_raddr,
  output chd_pkg::class_entry_t      cls_rdata,
  input  wire                        sym_we,
  input  wire  [SymAw-1:0]           sym_waddr,
  input  wire  [7:0]                 sym_wdata,
  input  wire  [SymAw-1:0]           sym_raddr,
  output logic [7:0]                 sym_rdata
);
  import chd_pkg::*;

  class_entry_t cls_mem [MAX_LENGTH_CLASSES];
  logic [7:0]   sym_mem [NUM_SYMBOLS];

  always_ff @(posedge clk) begin
    if (cls_we) begin
      cls_mem[cls_waddr] <= cls_wdata;
    end
    cls_rdata <= cls_mem[cls_raddr];
  end

  always_ff @(posedge clk) begin
    if (sym_we) begin
      sym_mem[sym_waddr] <= sym_wdata;
    end
    sym_rdata <= sym_mem[sym_raddr];
  end

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for canonical_huffman_decoder: random streams under idling phases.
// Depends on chd_pkg and the decoder RTL; predicts symbols from its own table model.
module tb;
  import chd_pkg::*;

  localparam int WatchdogLimit = 30000;
  localparam int DrainCycles   = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  canonical_huffman_decoder dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk = ~clk;

  // Shadow of the decoder: class table, symbol table, bit window and the register.
  logic [5:0]  cls_len [MaxLengthClassesDef];
  logic [31:0] cls_first [MaxLengthClassesDef];
  logic [7:0]  cls_rank [MaxLengthClassesDef];
  logic [7:0]  sym_by_rank [NumSymbolsDef];
  logic [63:0] window = '0;
  int unsigned held = 0;
  logic [5:0]  num_lengths = 6'd1;

  in_t  request_q[$];      // requests waiting for the driver
  out_t symbols_due[$];    // decoded symbols still to arrive
  int   idle_mode = 0;     // 0 none, 1 sender, 2 receiver, 3 both
  int   hold_cycles = 0;   // long receiver hold-off, counted down by the monitor
  int   errors = 0;
  int   requests_sent = 0;
  int   symbols_seen = 0;
  int   quiet = 0;
  bit   cfg_busy = 1'b0;

  // Decode one request into the expected symbol stream and advance the shadow state.
  task automatic decode_request(in_t r);
    logic [31:0] word, top, off;
    int unsigned add, cnt, d, l, n;
    out_t s;
    if (r.func == FUNC_CLASS) begin
      if (r.entry_index < MaxLengthClassesDef) begin
        cls_len[r.entry_index] = r.class_length;
        cls_first[r.entry_index] = r.class_first_code;
        cls_rank[r.entry_index] = r.class_rank;
      end
      return;
    end
    if (r.func == FUNC_SYMBOL) begin
      sym_by_rank[r.entry_index] = r.symbol_value;
      return;
    end
    if (r.func != FUNC_DATA) return;   // unknown function: drop

    word = r.data_word;
    add = 32;
    if (r.last_word) begin
      add = (r.last_word_bits > 32) ? 32 : r.last_word_bits;
      if (add == 0) word = '0;
      else if (add < 32) word &= ~(32'hFFFF_FFFF >> add);
    end
    window |= {32'd0, word} << (32 - (held & 31));
    held += add;
    cnt = (num_lengths == 0) ? 1 : (num_lengths > 32) ? 32 : num_lengths;
    n = 0;
    forever begin
      if (r.last_word ? (held == 0) : (held < MaxCodeBitsDef)) break;
      if (n >= 64) break;
      top = window[63:32];
      d = 0;
      while (d + 1 < cnt && top >= cls_first[d + 1]) d++;
      l = (cls_len[d] == 0) ? 1 : (cls_len[d] > 32) ? 32 : cls_len[d];
      off = (top - cls_first[d]) >> (32 - l);
      s = '0;
      s.symbol = sym_by_rank[(cls_rank[d] + off) & 8'hFF];
      s.code_length = l[5:0];
      window = window << l;
      if (l >= held) begin
        s.overrun = (l > held);
        held = 0;
      end else begin
        held -= l;
      end
      symbols_due.push_back(s);
      n++;
    end
    if (n > 0) begin
      symbols_due[$].last_of_run = 1'b1;
      if (r.last_word) symbols_due[$].end_of_message = 1'b1;
    end
    if (r.last_word) begin
      window = '0;
      held = 0;
    end
  endtask

  // Driver: predict on acceptance, then offer the next request or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_request(in_data);
        requests_sent++;
      end
      if (!in_valid || in_ready) begin
        if (request_q.size() > 0 &&
            !((idle_mode == 1 && $urandom_range(99) < 67) ||
              (idle_mode == 3 && $urandom_range(99) < 25))) begin
          in_valid <= 1'b1;
          in_data <= request_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted symbol against the oldest expectation.
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && out_ready) begin
      symbols_seen++;
      if (symbols_due.size() == 0) begin
        $error("unexpected symbol %0d", out_data.symbol);
        errors++;
      end else begin
        e = symbols_due.pop_front();
        if (out_data.symbol != e.symbol) begin
          $error("symbol: expected %0d, got %0d", e.symbol, out_data.symbol); errors++;
        end
        if (out_data.code_length != e.code_length) begin
          $error("code_length: expected %0d, got %0d", e.code_length, out_data.code_length);
          errors++;
        end
        if (out_data.last_of_run != e.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", e.last_of_run, out_data.last_of_run);
          errors++;
        end
        if (out_data.end_of_message != e.end_of_message) begin
          $error("end_of_message: expected %0d, got %0d", e.end_of_message,
                 out_data.end_of_message);
          errors++;
        end
        if (out_data.overrun != e.overrun) begin
          $error("overrun: expected %0d, got %0d", e.overrun, out_data.overrun); errors++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !((idle_mode == 2 && $urandom_range(99) < 67) ||
                     (idle_mode == 3 && $urandom_range(99) < 25));
    end
  end

  // Watchdog: count cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_busy) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchdogLimit) begin
      $display("canonical_huffman_decoder test failed");
      $finish;
    end
  end

  function automatic in_t noise();
    logic [127:0] raw;
    in_t r;
    raw = {$urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(in_t)-1:0];
    return r;
  endfunction

  function automatic in_t class_load(int idx, int len, logic [31:0] first, int rank);
    in_t r;
    r = noise();
    r.func = FUNC_CLASS;
    r.entry_index = 8'(idx);
    r.class_length = 6'(len);
    r.class_first_code = first;
    r.class_rank = 8'(rank);
    return r;
  endfunction

  function automatic in_t data_word(logic [31:0] w, bit last, int bits);
    in_t r;
    r = noise();
    r.func = FUNC_DATA;
    r.data_word = w;
    r.last_word = last;
    r.last_word_bits = 6'(bits);
    return r;
  endfunction

  // Hold until the block has drained and is idle.
  task automatic wait_idle();
    while (request_q.size() > 0 || in_valid || symbols_due.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write num_lengths through setup and access cycles.
  task automatic write_num_lengths(logic [5:0] v);
    cfg_busy = 1'b1;
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0;
    pwdata <= {26'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    num_lengths = v;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cfg_busy = 1'b0;
  endtask

  // Load a sorted class table with random content, then random messages.
  task automatic run_phase(logic [5:0] nl, int mode, int words);
    logic [31:0] firsts[$];
    int cnt, len, left;
    wait_idle();
    write_num_lengths(nl);
    idle_mode = mode;
    cnt = (nl == 0) ? 1 : (nl > 32) ? 32 : nl;
    for (int i = 0; i < cnt; i++) firsts.push_back(i == 0 ? 32'd0 : $urandom);
    firsts.sort();
    len = $urandom_range(1, 4);
    for (int i = 0; i < cnt; i++) begin
      request_q.push_back(class_load(i, len, firsts[i], $urandom_range(255)));
      if (len < 32) len += $urandom_range(0, 2);
      if (len > 32) len = 32;
    end
    left = words;
    while (left > 0) begin
      int msg;
      msg = $urandom_range(1, 5);
      for (int w = 0; w < msg && left > 0; w++, left--) begin
        if ($urandom_range(99) < 8) begin
          in_t z;
          z = noise();   // stray loads and unknown functions mixed in
          if (z.func == FUNC_DATA) z.func = 2'd3;
          if (z.func == FUNC_CLASS) z.entry_index = 8'($urandom_range(32, 255));
          request_q.push_back(z);
        end
        request_q.push_back(data_word($urandom, (w == msg - 1) || left == 1,
                                      $urandom_range(0, 63)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the symbol table so that every later lookup hits a written entry.
    for (int i = 0; i < NumSymbolsDef; i++) begin
      in_t r;
      r = noise();
      r.func = FUNC_SYMBOL;
      r.entry_index = 8'(i);
      r.symbol_value = 8'($urandom);
      request_q.push_back(r);
    end

    // Directed: lengths at both extremes, odd bit counts, ignored items.
    wait_idle();
    write_num_lengths(6'd2);
    request_q.push_back(class_load(0, 0, 32'h0000_0000, 255));        // zero length acts as one
    request_q.push_back(class_load(1, 63, 32'h8000_0000, 250));       // long length saturates
    request_q.push_back(class_load(40, 5, 32'hFFFF_FFFF, 7));         // out-of-table slot
    request_q.push_back('{func: 2'd3, default: '1});                  // unknown function
    request_q.push_back(data_word(32'h0F0F_0F0F, 1'b0, 0));
    request_q.push_back(data_word(32'hFFFF_FFFF, 1'b0, 0));
    request_q.push_back(data_word(32'hFFFF_FFFF, 1'b1, 5));           // overrun on the tail
    request_q.push_back(data_word(32'hFFFF_FFFF, 1'b1, 0));           // no bits at all
    request_q.push_back(data_word(32'h5555_5555, 1'b1, 63));          // bit count saturates
    request_q.push_back(data_word(32'h0000_0000, 1'b1, 32));
    request_q.push_back(data_word(32'h8000_0000, 1'b1, 1));
    request_q.push_back(data_word(32'hA5A5_A5A5, 1'b0, 32));
    request_q.push_back(data_word(32'h3C3C_3C3C, 1'b1, 31));

    run_phase(6'd63, 2, 6);
    run_phase(6'd0, 3, 4);
    run_phase(6'($urandom_range(2, 6)), 1, 6);
    run_phase(6'd1, 0, 6);
    hold_cycles = 400;   // receiver backs off while the sender keeps offering
    run_phase(6'($urandom_range(2, 6)), 3, 6);

    wait_idle();
    $display("Covered %0d requests and %0d symbols with class counts from zero to past",
             requests_sent, symbols_seen);
    $display("the table depth, sender gaps, receiver stalls and a long receiver hold-off.");
    if (errors == 0) begin
      $display("canonical_huffman_decoder test passed");
    end else begin
      $display("canonical_huffman_decoder test failed");
    end
    $finish;
  end
endmodule
